// ===== design/lu_pivot_solver_defines.svh =====
// ----------------------------------------------------------------------------
// lu_pivot_solver_defines.svh
// Assertion macros for the LU pivot solver. Simulation builds get concurrent
// assertions; synthesis builds get empty bodies.
// ----------------------------------------------------------------------------
`ifndef LU_PIVOT_SOLVER_DEFINES_SVH
`define LU_PIVOT_SOLVER_DEFINES_SVH

`ifndef SYNTHESIS
// Implication checked in the same cycle.
`define LU_ASSERT_NOW(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);
// Implication checked in the next cycle.
`define LU_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);
`else
`define LU_ASSERT_NOW(label, pre, post, msg)
`define LU_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

// ===== design/lu_pkg.sv =====
// ----------------------------------------------------------------------------
// lu_pkg
// Types, constants and fixed-point helpers shared by the LU pivot solver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lu_pkg;

   // Number format and array geometry.
   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int MAX_ORDER = 8;
   localparam int IDX_BITS  = 3;
   localparam int CNT_BITS  = 4;
   localparam int ADDR_BITS = 2 * IDX_BITS;
   localparam int QUOT_BITS = WORD_BITS + FRAC_BITS;
   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int THR_BITS  = 31;
   localparam int SIZE_BITS = 4;

   localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   // Configuration register indexes.
   localparam logic CSR_MATRIX_SIZE = 1'b0;
   localparam logic CSR_PIVOT_THR   = 1'b1;

   typedef enum logic [1:0] {
      REQ_LOAD_MATRIX = 2'd0,
      REQ_LOAD_RHS    = 2'd1,
      REQ_DECOMPOSE   = 2'd2,
      REQ_SOLVE       = 2'd3
   } lu_req_kind_type;

   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_SINGULAR   = 2'd1,
      STAT_NO_FACTORS = 2'd2
   } lu_status_type;

   typedef struct packed {
      logic [1:0]                  req_type;
      logic [IDX_BITS-1:0]         row_index;
      logic [IDX_BITS-1:0]         col_index;
      logic signed [WORD_BITS-1:0] entry_value;
   } lu_req_type;

   typedef struct packed {
      logic [IDX_BITS-1:0]         result_index;
      logic signed [WORD_BITS-1:0] solution_value;
      logic [1:0]                  status;
      logic [IDX_BITS-1:0]         swap_tally;
      logic                        last;
   } lu_rsp_type;

   // Datapath operations issued by the controller.
   typedef enum logic [4:0] {
      DP_NOP,
      DP_LOAD_RHS,
      DP_BEST_INIT,
      DP_BEST_UPD,
      DP_HOLD_TMP,
      DP_HOLD_PIV,
      DP_DIV_M,
      DP_DIV_X,
      DP_TAKE_L,
      DP_MUL_L,
      DP_MUL_X,
      DP_SAT,
      DP_X_SUB,
      DP_X_QUOT,
      DP_X_LOAD,
      DP_X_TMP,
      DP_X_MOVE,
      DP_X_FROM_TMP,
      DP_SWAP_CLR,
      DP_SWAP_INC
   } lu_dp_op_type;

   // Source of the matrix memory write data.
   typedef enum logic [2:0] {
      WS_ENTRY,
      WS_RD,
      WS_TMP,
      WS_DIFF,
      WS_QUOT
   } lu_wsel_type;

   typedef enum logic [5:0] {
      S_IDLE,
      S_SRCH_RD, S_SRCH_CMP, S_PIV_CHK,
      S_SWP_A, S_SWP_B, S_SWP_C, S_SWP_D,
      S_ELM_RDP, S_ELM_GETP, S_ELM_RDL, S_ELM_DIV, S_ELM_WAIT, S_ELM_WRL,
      S_UPD_RD, S_UPD_MUL, S_UPD_SAT, S_UPD_WR,
      S_XLOAD, S_PRM_A, S_PRM_B, S_PRM_C,
      S_FWD_CHK, S_FWD_RD, S_FWD_MUL, S_FWD_SAT, S_FWD_WR,
      S_BCK_CHK, S_BCK_RD, S_BCK_MUL, S_BCK_SAT, S_BCK_WR,
      S_BCK_RDD, S_BCK_TST, S_BCK_WAIT, S_BCK_WRQ,
      S_OUT, S_OUT_ERR
   } lu_state_type;

   typedef struct packed {
      lu_dp_op_type         op;
      logic [ADDR_BITS-1:0] rd_addr;
      logic                 wr_en;
      logic [ADDR_BITS-1:0] wr_addr;
      lu_wsel_type          wr_sel;
      logic [IDX_BITS-1:0]  xr;
      logic [IDX_BITS-1:0]  xw;
      logic [IDX_BITS-1:0]  res_index;
      lu_status_type        res_status;
      logic                 res_last;
   } lu_cmd_type;

   typedef struct packed {
      logic gt_best;
      logic best_low;
      logic rd_low;
      logic div_busy;
   } lu_stat_type;

   // Magnitude of a two's complement word, as an unsigned word.
   function automatic logic [WORD_BITS-1:0] mag_of(input logic signed [WORD_BITS-1:0] v);
      mag_of = v[WORD_BITS-1] ? (~v + 1'b1) : v;
   endfunction

   // Applies a sign to a magnitude and saturates to the word range.
   function automatic logic signed [WORD_BITS-1:0] from_mag(input logic neg,
                                                            input logic [QUOT_BITS-1:0] m);
      logic [QUOT_BITS-1:0] lim;
      logic [WORD_BITS-1:0] lo;
      lim = {{(QUOT_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}} + QUOT_BITS'(neg);
      lo  = m[WORD_BITS-1:0];
      if (m > lim) begin
         from_mag = neg ? WORD_MIN : WORD_MAX;
      end else begin
         from_mag = neg ? (~lo + 1'b1) : lo;
      end
   endfunction

   // Saturating subtraction.
   function automatic logic signed [WORD_BITS-1:0] sat_sub(input logic signed [WORD_BITS-1:0] a,
                                                           input logic signed [WORD_BITS-1:0] b);
      logic [WORD_BITS:0] d;
      d = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
      if (d[WORD_BITS] != d[WORD_BITS-1]) begin
         sat_sub = d[WORD_BITS] ? WORD_MIN : WORD_MAX;
      end else begin
         sat_sub = d[WORD_BITS-1:0];
      end
   endfunction

endpackage

`default_nettype wire

// ===== design/lu_pivot_solver.sv =====
// ----------------------------------------------------------------------------
// lu_pivot_solver
// Square linear solver in signed Q16.16: LU factorization with partial
// pivoting, then permutation, forward and back substitution.
//
//   Channel   Direction  Handshake            Payload
//   req_*     in         req_valid/req_stall  lu_req_type
//   rsp_*     out        rsp_valid/rsp_stall  lu_rsp_type
//   csr_*     in         csr_write_en         csr_index, csr_wdata
//
// A decompose request divides once per subdiagonal entry, n(n-1)/2 times,
// and the serial divider sets its total time. No item is taken while a
// request is being worked or its results wait; results hold while rsp_stall
// is high. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "lu_pivot_solver_defines.svh"

module lu_pivot_solver (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire lu_pkg::lu_req_type            req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output lu_pkg::lu_rsp_type                 rsp_data,
   input  wire logic                          csr_write_en,
   input  wire logic                          csr_index,
   input  wire logic [lu_pkg::THR_BITS-1:0]   csr_wdata
);
   import lu_pkg::*;

   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic [THR_BITS-1:0]  thr_ff, thr_in;
   logic [CNT_BITS-1:0]  order_n;
   logic                 size_wr;
   lu_cmd_type           cmd;
   lu_stat_type          stat;

   // Configuration registers.
   assign size_wr = csr_write_en && (csr_index == CSR_MATRIX_SIZE);

   always_comb begin
      size_in = size_ff;
      thr_in  = thr_ff;
      if (size_wr) begin
         size_in = csr_wdata[SIZE_BITS-1:0];
      end
      if (csr_write_en && csr_index == CSR_PIVOT_THR) begin
         thr_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_BITS'(MAX_ORDER);
         thr_ff  <= '0;
      end else begin
         size_ff <= size_in;
         thr_ff  <= thr_in;
      end
   end

   // Order in use: zero counts as one, oversize counts as the maximum.
   always_comb begin
      if (size_ff == '0) begin
         order_n = CNT_BITS'(1);
      end else if (size_ff > SIZE_BITS'(MAX_ORDER)) begin
         order_n = CNT_BITS'(MAX_ORDER);
      end else begin
         order_n = size_ff;
      end
   end

   lu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req       (req_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .order_n   (order_n),
      .size_wr   (size_wr),
      .stat      (stat),
      .cmd       (cmd)
   );

   lu_datapath u_datapath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .req   (req_data),
      .thr   (thr_ff),
      .stat  (stat),
      .rsp   (rsp_data)
   );

   // A decompose or solve request always makes the block busy in the following cycle.
   `LU_ASSERT_NEXT(a_solve_goes_busy, req_valid && !req_stall && req_data.req_type[1], req_stall, "solve request did not start work")
   // No item is taken while a result is offered.
   `LU_ASSERT_NOW(a_no_accept_during_rsp, rsp_valid, req_stall, "input open while result pending")
   // Error results end the run.
   `LU_ASSERT_NOW(a_error_is_last, rsp_valid && rsp_data.status != STAT_OK, rsp_data.last, "error result not last")
   // A run does not stop before its final result.
   `LU_ASSERT_NEXT(a_run_continues, rsp_valid && !rsp_stall && !rsp_data.last, rsp_valid, "result run cut short")

endmodule

`default_nettype wire

// ===== design/lu_div.sv =====
// ----------------------------------------------------------------------------
// lu_div
// Restoring fixed-point divider, one quotient bit per cycle, with saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lu_div (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic signed [lu_pkg::WORD_BITS-1:0] num,
   input  wire logic signed [lu_pkg::WORD_BITS-1:0] den,
   output logic                                     busy,
   output logic signed [lu_pkg::WORD_BITS-1:0]      quot
);
   import lu_pkg::*;

   localparam int STEP_BITS = $clog2(QUOT_BITS + 1);

   logic                   busy_ff, busy_in;
   logic [STEP_BITS-1:0]   cnt_ff, cnt_in;
   logic [QUOT_BITS-1:0]   work_ff, work_in;
   logic [WORD_BITS-1:0]   rem_ff, rem_in;
   logic [WORD_BITS-1:0]   den_ff, den_in;
   logic                   neg_ff, neg_in;
   logic                   dzero_ff, dzero_in;
   logic                   nzero_ff, nzero_in;
   logic [WORD_BITS:0]     trial;
   logic [WORD_BITS:0]     diff;
   logic                   fits;

   // One restoring step: shift in the next numerator bit and try to subtract.
   assign trial = {rem_ff, work_ff[QUOT_BITS-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      work_in  = work_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      dzero_in = dzero_ff;
      nzero_in = nzero_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = STEP_BITS'(QUOT_BITS);
         work_in  = {mag_of(num), {FRAC_BITS{1'b0}}};
         rem_in   = '0;
         den_in   = mag_of(den);
         neg_in   = num[WORD_BITS-1] ^ den[WORD_BITS-1];
         dzero_in = (den == '0);
         nzero_in = (num != '0);
      end else if (busy_ff) begin
         rem_in  = fits ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
         work_in = {work_ff[QUOT_BITS-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      work_ff  <= work_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      neg_ff   <= neg_in;
      dzero_ff <= dzero_in;
      nzero_ff <= nzero_in;
   end

   // A zero divisor saturates a nonzero dividend and gives zero otherwise.
   always_comb begin
      if (dzero_ff) begin
         quot = nzero_ff ? (neg_ff ? WORD_MIN : WORD_MAX) : '0;
      end else begin
         quot = from_mag(neg_ff, work_ff);
      end
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

// ===== design/lu_datapath.sv =====
// ----------------------------------------------------------------------------
// lu_datapath
// Matrix memory, right-hand and solution vectors, multiplier, divider and
// pivot search registers of the LU pivot solver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lu_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lu_pkg::lu_cmd_type            cmd,
   input  wire lu_pkg::lu_req_type            req,
   input  wire logic [lu_pkg::THR_BITS-1:0]   thr,
   output lu_pkg::lu_stat_type                stat,
   output lu_pkg::lu_rsp_type                 rsp
);
   import lu_pkg::*;

   localparam int DEPTH = MAX_ORDER * MAX_ORDER;

   logic signed [WORD_BITS-1:0] mat_mem [DEPTH];
   logic signed [WORD_BITS-1:0] rd_ff;
   logic signed [WORD_BITS-1:0] wr_data;

   logic [WORD_BITS-1:0]        best_ff, best_in;
   logic signed [WORD_BITS-1:0] piv_ff, piv_in;
   logic signed [WORD_BITS-1:0] tmp_ff, tmp_in;
   logic signed [WORD_BITS-1:0] l_ff, l_in;
   logic [PROD_BITS-1:0]        prod_ff, prod_in;
   logic                        pneg_ff, pneg_in;
   logic signed [WORD_BITS-1:0] mres_ff, mres_in;
   logic signed [WORD_BITS-1:0] x_ff [MAX_ORDER];
   logic signed [WORD_BITS-1:0] x_in [MAX_ORDER];
   logic signed [WORD_BITS-1:0] wv_ff [MAX_ORDER];
   logic signed [WORD_BITS-1:0] wv_in [MAX_ORDER];
   logic [IDX_BITS-1:0]         swap_ff, swap_in;

   logic [WORD_BITS-1:0]        rd_mag;
   logic signed [WORD_BITS-1:0] x_rd;
   logic                        div_start;
   logic signed [WORD_BITS-1:0] div_num, div_den, div_q;
   logic                        div_busy;

   assign rd_mag = mag_of(rd_ff);
   assign x_rd   = x_ff[cmd.xr];

   // Divider operands: matrix entry over pivot, or solution entry over diagonal.
   assign div_start = (cmd.op == DP_DIV_M) || (cmd.op == DP_DIV_X);
   assign div_num   = (cmd.op == DP_DIV_X) ? x_rd : rd_ff;
   assign div_den   = (cmd.op == DP_DIV_X) ? rd_ff : piv_ff;

   lu_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quot  (div_q)
   );

   // Memory write data selection.
   always_comb begin
      case (cmd.wr_sel)
         WS_ENTRY: wr_data = req.entry_value;
         WS_RD:    wr_data = rd_ff;
         WS_TMP:   wr_data = tmp_ff;
         WS_DIFF:  wr_data = sat_sub(rd_ff, mres_ff);
         WS_QUOT:  wr_data = div_q;
         default:  wr_data = rd_ff;
      endcase
   end

   // Matrix memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mat_mem[cmd.wr_addr] <= wr_data;
      end
      rd_ff <= mat_mem[cmd.rd_addr];
   end

   // Register updates per datapath operation.
   always_comb begin
      best_in = best_ff;
      piv_in  = piv_ff;
      tmp_in  = tmp_ff;
      l_in    = l_ff;
      prod_in = prod_ff;
      pneg_in = pneg_ff;
      mres_in = mres_ff;
      x_in    = x_ff;
      wv_in   = wv_ff;
      swap_in = swap_ff;
      case (cmd.op)
         DP_LOAD_RHS:   wv_in[req.row_index] = req.entry_value;
         DP_BEST_INIT:  best_in = rd_mag;
         DP_BEST_UPD: begin
            if (rd_mag > best_ff) begin
               best_in = rd_mag;
            end
         end
         DP_HOLD_TMP:   tmp_in = rd_ff;
         DP_HOLD_PIV:   piv_in = rd_ff;
         DP_TAKE_L:     l_in = div_q;
         DP_MUL_L: begin
            prod_in = mag_of(l_ff) * mag_of(rd_ff);
            pneg_in = l_ff[WORD_BITS-1] ^ rd_ff[WORD_BITS-1];
         end
         DP_MUL_X: begin
            prod_in = mag_of(rd_ff) * mag_of(x_rd);
            pneg_in = rd_ff[WORD_BITS-1] ^ x_rd[WORD_BITS-1];
         end
         DP_SAT:        mres_in = from_mag(pneg_ff, prod_ff[FRAC_BITS +: QUOT_BITS]);
         DP_X_SUB:      x_in[cmd.xw] = sat_sub(x_rd, mres_ff);
         DP_X_QUOT:     x_in[cmd.xw] = div_q;
         DP_X_LOAD:     x_in = wv_ff;
         DP_X_TMP:      tmp_in = x_rd;
         DP_X_MOVE:     x_in[cmd.xw] = x_rd;
         DP_X_FROM_TMP: x_in[cmd.xw] = tmp_ff;
         DP_SWAP_CLR:   swap_in = '0;
         DP_SWAP_INC:   swap_in = swap_ff + 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         swap_ff <= '0;
      end else begin
         swap_ff <= swap_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
      piv_ff  <= piv_in;
      tmp_ff  <= tmp_in;
      l_ff    <= l_in;
      prod_ff <= prod_in;
      pneg_ff <= pneg_in;
      mres_ff <= mres_in;
      x_ff    <= x_in;
      wv_ff   <= wv_in;
   end

   // Status back to the controller.
   assign stat.gt_best  = rd_mag > best_ff;
   assign stat.best_low = best_ff <= {1'b0, thr};
   assign stat.rd_low   = rd_mag <= {1'b0, thr};
   assign stat.div_busy = div_busy;

   // Result item: solution entries carry a value, error items carry zero.
   assign rsp.result_index   = cmd.res_index;
   assign rsp.solution_value = (cmd.res_status == STAT_OK) ? x_rd : '0;
   assign rsp.status         = cmd.res_status;
   assign rsp.swap_tally     = (cmd.res_status == STAT_NO_FACTORS) ? '0 : swap_ff;
   assign rsp.last           = cmd.res_last;

endmodule

`default_nettype wire

// ===== design/lu_ctrl.sv =====
// ----------------------------------------------------------------------------
// lu_ctrl
// Sequencer of the LU pivot solver: walks the factorization, permutation,
// forward and back substitution loops and drives the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lu_ctrl (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   input  wire lu_pkg::lu_req_type              req,
   output logic                                 req_stall,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   input  wire logic [lu_pkg::CNT_BITS-1:0]     order_n,
   input  wire logic                            size_wr,
   input  wire lu_pkg::lu_stat_type             stat,
   output lu_pkg::lu_cmd_type                   cmd
);
   import lu_pkg::*;

   lu_state_type         state_ff, state_in;
   logic [CNT_BITS-1:0]  k_ff, k_in;
   logic [CNT_BITS-1:0]  i_ff, i_in;
   logic [CNT_BITS-1:0]  j_ff, j_in;
   logic [IDX_BITS-1:0]  p_ff, p_in;
   logic                 fv_ff, fv_in;
   lu_status_type        err_ff, err_in;
   logic [IDX_BITS-1:0]  prow_ff [MAX_ORDER];
   logic [IDX_BITS-1:0]  prow_in [MAX_ORDER];

   logic [IDX_BITS-1:0]  ki, ii, ji;
   logic [IDX_BITS-1:0]  prow_i;
   logic                 perm;
   logic [CNT_BITS-1:0]  k_nx, i_nx, j_nx;

   assign ki     = k_ff[IDX_BITS-1:0];
   assign ii     = i_ff[IDX_BITS-1:0];
   assign ji     = j_ff[IDX_BITS-1:0];
   assign k_nx   = k_ff + 1'b1;
   assign i_nx   = i_ff + 1'b1;
   assign j_nx   = j_ff + 1'b1;
   assign prow_i = prow_ff[ii];
   assign perm   = (prow_i != ii) && ({1'b0, prow_i} < order_n);

   // Next state and loop counters.
   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      p_in     = p_ff;
      fv_in    = fv_ff;
      err_in   = err_ff;
      prow_in  = prow_ff;
      case (state_ff)
         S_IDLE: begin
            if (size_wr) begin
               fv_in = 1'b0;
            end
            if (req_valid) begin
               case (req.req_type)
                  REQ_LOAD_MATRIX: fv_in = 1'b0;
                  REQ_DECOMPOSE: begin
                     k_in     = '0;
                     i_in     = '0;
                     state_in = S_SRCH_RD;
                  end
                  REQ_SOLVE: begin
                     if (fv_ff) begin
                        state_in = S_XLOAD;
                     end else begin
                        err_in   = STAT_NO_FACTORS;
                        state_in = S_OUT_ERR;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SRCH_RD: state_in = S_SRCH_CMP;
         S_SRCH_CMP: begin
            if (i_ff == k_ff) begin
               p_in = ki;
            end else if (stat.gt_best) begin
               p_in = ii;
            end
            if (i_nx < order_n) begin
               i_in     = i_nx;
               state_in = S_SRCH_RD;
            end else begin
               state_in = S_PIV_CHK;
            end
         end
         S_PIV_CHK: begin
            if (stat.best_low) begin
               fv_in    = 1'b0;
               err_in   = STAT_SINGULAR;
               state_in = S_OUT_ERR;
            end else begin
               prow_in[ki] = p_ff;
               if (p_ff != ki) begin
                  j_in     = '0;
                  state_in = S_SWP_A;
               end else begin
                  state_in = S_ELM_RDP;
               end
            end
         end
         S_SWP_A: state_in = S_SWP_B;
         S_SWP_B: state_in = S_SWP_C;
         S_SWP_C: state_in = S_SWP_D;
         S_SWP_D: begin
            if (j_nx < order_n) begin
               j_in     = j_nx;
               state_in = S_SWP_A;
            end else begin
               state_in = S_ELM_RDP;
            end
         end
         S_ELM_RDP: state_in = S_ELM_GETP;
         S_ELM_GETP: begin
            i_in = k_nx;
            if (k_nx < order_n) begin
               state_in = S_ELM_RDL;
            end else begin
               fv_in    = 1'b1;
               state_in = S_XLOAD;
            end
         end
         S_ELM_RDL: state_in = S_ELM_DIV;
         S_ELM_DIV: state_in = S_ELM_WAIT;
         S_ELM_WAIT: begin
            if (!stat.div_busy) begin
               state_in = S_ELM_WRL;
            end
         end
         S_ELM_WRL: begin
            j_in     = k_nx;
            state_in = S_UPD_RD;
         end
         S_UPD_RD:  state_in = S_UPD_MUL;
         S_UPD_MUL: state_in = S_UPD_SAT;
         S_UPD_SAT: state_in = S_UPD_WR;
         S_UPD_WR: begin
            if (j_nx < order_n) begin
               j_in     = j_nx;
               state_in = S_UPD_RD;
            end else if (i_nx < order_n) begin
               i_in     = i_nx;
               state_in = S_ELM_RDL;
            end else begin
               // Column done: move to the next pivot column.
               k_in     = k_nx;
               i_in     = k_nx;
               state_in = S_SRCH_RD;
            end
         end
         S_XLOAD: begin
            i_in     = '0;
            state_in = S_PRM_A;
         end
         S_PRM_A, S_PRM_C: begin
            if (state_ff == S_PRM_A && perm) begin
               state_in = S_PRM_B;
            end else if (i_nx < order_n) begin
               i_in     = i_nx;
               state_in = S_PRM_A;
            end else begin
               i_in     = '0;
               j_in     = '0;
               state_in = S_FWD_CHK;
            end
         end
         S_PRM_B: state_in = S_PRM_C;
         S_FWD_CHK: begin
            if (i_ff == order_n) begin
               i_in     = order_n - 1'b1;
               j_in     = order_n;
               state_in = S_BCK_CHK;
            end else if (j_ff < i_ff) begin
               state_in = S_FWD_RD;
            end else begin
               i_in = i_nx;
               j_in = '0;
            end
         end
         S_FWD_RD:  state_in = S_FWD_MUL;
         S_FWD_MUL: state_in = S_FWD_SAT;
         S_FWD_SAT: state_in = S_FWD_WR;
         S_FWD_WR: begin
            j_in     = j_nx;
            state_in = S_FWD_CHK;
         end
         S_BCK_CHK: begin
            if (j_ff < order_n) begin
               state_in = S_BCK_RD;
            end else begin
               state_in = S_BCK_RDD;
            end
         end
         S_BCK_RD:  state_in = S_BCK_MUL;
         S_BCK_MUL: state_in = S_BCK_SAT;
         S_BCK_SAT: state_in = S_BCK_WR;
         S_BCK_WR: begin
            j_in     = j_nx;
            state_in = S_BCK_CHK;
         end
         S_BCK_RDD: state_in = S_BCK_TST;
         S_BCK_TST: begin
            if (stat.rd_low) begin
               err_in   = STAT_SINGULAR;
               state_in = S_OUT_ERR;
            end else begin
               state_in = S_BCK_WAIT;
            end
         end
         S_BCK_WAIT: begin
            if (!stat.div_busy) begin
               state_in = S_BCK_WRQ;
            end
         end
         S_BCK_WRQ: begin
            if (i_ff == '0) begin
               state_in = S_OUT;
            end else begin
               j_in     = i_ff;
               i_in     = i_ff - 1'b1;
               state_in = S_BCK_CHK;
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               if (i_nx == order_n) begin
                  state_in = S_IDLE;
               end else begin
                  i_in = i_nx;
               end
            end
         end
         S_OUT_ERR: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fv_ff    <= 1'b0;
         k_ff     <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         fv_ff    <= fv_in;
         k_ff     <= k_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff    <= p_in;
      err_ff  <= err_in;
      prow_ff <= prow_in;
   end

   // Datapath commands and handshake outputs.
   always_comb begin
      cmd            = '0;
      cmd.op         = DP_NOP;
      cmd.wr_sel     = WS_ENTRY;
      cmd.res_status = STAT_OK;
      req_stall      = 1'b1;
      rsp_valid      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               case (req.req_type)
                  REQ_LOAD_MATRIX: begin
                     cmd.wr_en   = 1'b1;
                     cmd.wr_addr = {req.row_index, req.col_index};
                     cmd.wr_sel  = WS_ENTRY;
                  end
                  REQ_LOAD_RHS:  cmd.op = DP_LOAD_RHS;
                  REQ_DECOMPOSE: cmd.op = DP_SWAP_CLR;
                  default: begin
                  end
               endcase
            end
         end
         S_SRCH_RD:  cmd.rd_addr = {ii, ki};
         S_SRCH_CMP: cmd.op = (i_ff == k_ff) ? DP_BEST_INIT : DP_BEST_UPD;
         S_PIV_CHK: begin
            if (!stat.best_low && p_ff != ki) begin
               cmd.op = DP_SWAP_INC;
            end
         end
         S_SWP_A: cmd.rd_addr = {ki, ji};
         S_SWP_B: begin
            cmd.op      = DP_HOLD_TMP;
            cmd.rd_addr = {p_ff, ji};
         end
         S_SWP_C: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = {ki, ji};
            cmd.wr_sel  = WS_RD;
         end
         S_SWP_D: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = {p_ff, ji};
            cmd.wr_sel  = WS_TMP;
         end
         S_ELM_RDP:  cmd.rd_addr = {ki, ki};
         S_ELM_GETP: cmd.op = DP_HOLD_PIV;
         S_ELM_RDL:  cmd.rd_addr = {ii, ki};
         S_ELM_DIV:  cmd.op = DP_DIV_M;
         S_ELM_WRL: begin
            cmd.op      = DP_TAKE_L;
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = {ii, ki};
            cmd.wr_sel  = WS_QUOT;
         end
         S_UPD_RD: cmd.rd_addr = {ki, ji};
         S_UPD_MUL: begin
            cmd.op      = DP_MUL_L;
            cmd.rd_addr = {ii, ji};
         end
         S_UPD_SAT: begin
            cmd.op      = DP_SAT;
            cmd.rd_addr = {ii, ji};
         end
         S_UPD_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = {ii, ji};
            cmd.wr_sel  = WS_DIFF;
         end
         S_XLOAD: cmd.op = DP_X_LOAD;
         S_PRM_A: begin
            if (perm) begin
               cmd.op = DP_X_TMP;
               cmd.xr = ii;
            end
         end
         S_PRM_B: begin
            cmd.op = DP_X_MOVE;
            cmd.xr = prow_i;
            cmd.xw = ii;
         end
         S_PRM_C: begin
            cmd.op = DP_X_FROM_TMP;
            cmd.xw = prow_i;
         end
         S_FWD_RD, S_BCK_RD: cmd.rd_addr = {ii, ji};
         S_FWD_MUL, S_BCK_MUL: begin
            cmd.op = DP_MUL_X;
            cmd.xr = ji;
         end
         S_FWD_SAT, S_BCK_SAT: cmd.op = DP_SAT;
         S_FWD_WR, S_BCK_WR: begin
            cmd.op = DP_X_SUB;
            cmd.xr = ii;
            cmd.xw = ii;
         end
         S_BCK_RDD: cmd.rd_addr = {ii, ii};
         S_BCK_TST: begin
            cmd.xr = ii;
            if (!stat.rd_low) begin
               cmd.op = DP_DIV_X;
            end
         end
         S_BCK_WRQ: begin
            cmd.op = DP_X_QUOT;
            cmd.xw = ii;
         end
         S_OUT: begin
            rsp_valid     = 1'b1;
            cmd.xr        = ii;
            cmd.res_index = ii;
            cmd.res_last  = (i_nx == order_n);
         end
         S_OUT_ERR: begin
            rsp_valid      = 1'b1;
            cmd.res_status = err_ff;
            cmd.res_last   = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire
